// ----- src/lwsel_pkg.sv -----
package lwsel_pkg;

   localparam int MAX_WAYPOINTS  = 1024;
   localparam int WINDOW_BACK    = 5;
   localparam int WINDOW_FORWARD = 15;
   localparam int IDX_W          = $clog2(MAX_WAYPOINTS);
   localparam int CNT_W          = IDX_W + 1;
   localparam int NUM_W          = 39;
   localparam int DIV_CNT_W      = $clog2(NUM_W);

   // (4 m)^2 and 8 m in Q32.32 / Q16.16
   localparam logic [64:0] LOOP_GAP_SQ = 65'd1 << 36;
   localparam logic [23:0] BAND        = 24'd8 << 16;

   localparam logic [1:0] CSR_LA_MIN     = 2'd0;
   localparam logic [1:0] CSR_LA_MAX     = 2'd1;
   localparam logic [1:0] CSR_SPEED_LOW  = 2'd2;
   localparam logic [1:0] CSR_SPEED_HIGH = 2'd3;

   typedef struct packed {
      logic               is_query;
      logic               new_path;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] speed;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REF,
      ST_LOOP,
      ST_MUL,
      ST_DIV,
      ST_LAFIN,
      ST_LASQ,
      ST_WIN,
      ST_TGT,
      ST_RESP
   } state_type;

endpackage

// ----- src/lookahead_waypoint_selector.sv -----
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   kind, new_path, wp_x/y, robot_x/y, speed
// rsp_      out        rsp_valid/rsp_stall   status, target_index, closest_index, in_loop
// csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// a load is written to memory as it is popped; a query's time grows with the window and the scan,
// window being 1 to 21 entries and scan the entries walked from the nearest index
// until a target hits (up to 1024); an empty-path query goes straight to the response
// the 39-step lookahead divider and the single-read waypoint memory set the query time
// reset is synchronous; path count, nearest index, queue and output register clear
// a two-entry queue lets the input keep taking transactions while the back end works,
// and the output register holds a result while the back end moves on
module lookahead_waypoint_selector (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic               req_new_path,
   input  logic signed [31:0] req_wp_x,
   input  logic signed [31:0] req_wp_y,
   input  logic signed [31:0] req_robot_x,
   input  logic signed [31:0] req_robot_y,
   input  logic signed [15:0] req_speed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_status,
   output logic [9:0]         rsp_target_index,
   output logic [9:0]         rsp_closest_index,
   output logic               rsp_in_loop,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [22:0]        csr_wdata
);
   import lwsel_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   lwsel_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_new_path (req_new_path),
      .req_wp_x     (req_wp_x),
      .req_wp_y     (req_wp_y),
      .req_robot_x  (req_robot_x),
      .req_robot_y  (req_robot_y),
      .req_speed    (req_speed),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   lwsel_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_target_index  (rsp_target_index),
      .rsp_closest_index (rsp_closest_index),
      .rsp_in_loop       (rsp_in_loop)
   );

endmodule

// ----- src/lwsel_front.sv -----
module lwsel_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_kind,
   input  logic                    req_new_path,
   input  logic signed [31:0]      req_wp_x,
   input  logic signed [31:0]      req_wp_y,
   input  logic signed [31:0]      req_robot_x,
   input  logic signed [31:0]      req_robot_y,
   input  logic signed [15:0]      req_speed,
   output logic                    cmd_valid,
   output lwsel_pkg::cmd_type      cmd,
   input  logic                    cmd_pop
);
   import lwsel_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       push;

   // loads carry the waypoint, queries the robot position
   always_comb begin
      cls.is_query = req_kind;
      cls.new_path = req_new_path;
      cls.pos_x    = req_kind ? req_robot_x : req_wp_x;
      cls.pos_y    = req_kind ? req_robot_y : req_wp_y;
      cls.speed    = req_speed;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      cnt_in    = 2'(cnt_ff + {1'b0, push} - {1'b0, cmd_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- src/lwsel_back.sv -----
module lwsel_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  lwsel_pkg::cmd_type      cmd,
   output logic                    cmd_pop,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [22:0]             csr_wdata,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_status,
   output logic [9:0]              rsp_target_index,
   output logic [9:0]              rsp_closest_index,
   output logic                    rsp_in_loop
);
   import lwsel_pkg::*;

   logic [63:0] mem [MAX_WAYPOINTS];
   logic [63:0] ram_q_ff;
   logic [IDX_W-1:0] rd_addr;
   logic        mem_we;
   logic [IDX_W-1:0] wr_addr;

   state_type state_ff, state_in;

   logic [22:0] la_min_ff, la_max_ff;
   logic [14:0] spd_lo_ff, spd_hi_ff;

   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] nearest_ff, last_ff;
   logic signed [31:0] rx_ff, ry_ff, ref_x_ff, ref_y_ff;
   logic signed [15:0] speed_ff;
   logic        loop_ff, status_ff;

   logic        issue_on_ff;
   logic [IDX_W-1:0] issue_idx_ff, issue_end_ff;
   logic        p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic        p1_end_ff, p2_end_ff, p3_end_ff;
   logic [IDX_W-1:0] p1_idx_ff, p2_idx_ff, p3_idx_ff;
   logic [31:0] dx_ff, dy_ff;
   logic [63:0] sx_ff, sy_ff;
   logic [64:0] cur_dsq;

   logic [IDX_W-1:0] best_ff, target_ff;
   logic [64:0] bestd_ff;
   logic        first_ff;

   logic [NUM_W-1:0] quo_ff;
   logic [15:0] rem_ff;
   logic [14:0] den_mag_ff;
   logic        neg_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [23:0] lu_ff, uu_ff;
   logic [47:0] lsq_ff, usq_ff;

   logic        rsp_valid_ff;
   logic        rsp_status_ff, rsp_in_loop_ff;
   logic [9:0]  rsp_target_ff, rsp_closest_ff;

   // combinational helpers
   logic        flush;
   logic        rsp_load;
   logic [IDX_W-1:0] last_w;
   logic signed [16:0] spd_s, lo_s, hi_s, c_s, clo_s, den_s;
   logic signed [23:0] dmm_s;
   logic [22:0] dmm_mag;
   logic [15:0] clo_mag;
   logic [14:0] den_mag;
   logic [15:0] div_t;
   logic        div_bit;
   logic [23:0] q_mag;
   logic signed [25:0] la_s;
   logic [23:0] la_u;
   logic [IDX_W-1:0] win_n, win_start, win_end;
   logic        better, hit;
   logic [IDX_W-1:0] best_fin;
   logic signed [32:0] ddx, ddy;

   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         la_min_ff <= '0;
         la_max_ff <= '0;
         spd_lo_ff <= '0;
         spd_hi_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LA_MIN:     la_min_ff <= csr_wdata;
            CSR_LA_MAX:     la_max_ff <= csr_wdata;
            CSR_SPEED_LOW:  spd_lo_ff <= csr_wdata[14:0];
            CSR_SPEED_HIGH: spd_hi_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // waypoint memory, one write and one read port
   assign rd_addr = issue_on_ff ? issue_idx_ff : '0;
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= {cmd.pos_y, cmd.pos_x};
      end
      ram_q_ff <= mem[rd_addr];
   end

   // lookahead arithmetic
   always_comb begin
      spd_s   = 17'(speed_ff);
      lo_s    = signed'({2'b00, spd_lo_ff});
      hi_s    = signed'({2'b00, spd_hi_ff});
      c_s     = (spd_s < lo_s) ? lo_s : ((spd_s > hi_s) ? hi_s : spd_s);
      clo_s   = c_s - lo_s;
      den_s   = hi_s - lo_s;
      dmm_s   = signed'({1'b0, la_max_ff}) - signed'({1'b0, la_min_ff});
      dmm_mag = dmm_s[23] ? 23'(-dmm_s) : dmm_s[22:0];
      clo_mag = clo_s[16] ? 16'(-clo_s) : clo_s[15:0];
      den_mag = den_s[16] ? 15'(-den_s) : den_s[14:0];
      div_t   = {rem_ff[14:0], quo_ff[NUM_W-1]};
      div_bit = (div_t >= {1'b0, den_mag_ff});
      q_mag   = (spd_hi_ff == spd_lo_ff) ? 24'd0 : quo_ff[23:0];
      la_s    = neg_ff ? (signed'({3'b000, la_min_ff}) - signed'({2'b00, q_mag}))
                       : (signed'({3'b000, la_min_ff}) + signed'({2'b00, q_mag}));
      la_u    = la_s[25] ? 24'd0 : la_s[23:0];
   end

   // search window around the remembered nearest index
   always_comb begin
      win_n     = (nearest_ff > last_ff) ? last_ff : nearest_ff;
      win_start = (win_n >= IDX_W'(WINDOW_BACK)) ? IDX_W'(win_n - IDX_W'(WINDOW_BACK)) : '0;
      win_end   = (IDX_W'(last_ff - win_n) > IDX_W'(WINDOW_FORWARD))
                  ? IDX_W'(win_n + IDX_W'(WINDOW_FORWARD)) : last_ff;
   end

   // distance pipeline
   always_comb begin
      ddx      = 33'(signed'(ram_q_ff[31:0])) - 33'(ref_x_ff);
      ddy      = 33'(signed'(ram_q_ff[63:32])) - 33'(ref_y_ff);
      cur_dsq  = {1'b0, sx_ff} + {1'b0, sy_ff};
      better   = first_ff || (cur_dsq < bestd_ff);
      best_fin = better ? p3_idx_ff : best_ff;
      hit      = ({17'd0, lsq_ff} < cur_dsq) && (cur_dsq < {17'd0, usq_ff});
      last_w   = IDX_W'(count_ff - CNT_W'(1));
   end

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      mem_we   = 1'b0;
      wr_addr  = cmd.new_path ? '0 : count_ff[IDX_W-1:0];
      flush    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (!cmd.is_query) begin
                  mem_we = cmd.new_path || (count_ff < CNT_W'(MAX_WAYPOINTS));
               end else if (count_ff == '0) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_REF;
               end
            end
         end
         ST_REF:   state_in = ST_LOOP;
         ST_LOOP:  if (p3_vld_ff) state_in = ST_MUL;
         ST_MUL:   state_in = ST_DIV;
         ST_DIV:   if (div_cnt_ff == DIV_CNT_W'(NUM_W - 1)) state_in = ST_LAFIN;
         ST_LAFIN: state_in = ST_LASQ;
         ST_LASQ:  state_in = ST_WIN;
         ST_WIN:   if (p3_vld_ff && p3_end_ff) state_in = ST_TGT;
         ST_TGT: begin
            if (p3_vld_ff && (hit || p3_end_ff)) begin
               flush    = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         nearest_ff  <= '0;
         issue_on_ff <= 1'b0;
         p1_vld_ff   <= 1'b0;
         p2_vld_ff   <= 1'b0;
         p3_vld_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            count_ff <= cmd.new_path ? CNT_W'(1) : CNT_W'(count_ff + CNT_W'(1));
         end
         if (flush) begin
            p1_vld_ff <= 1'b0;
            p2_vld_ff <= 1'b0;
            p3_vld_ff <= 1'b0;
         end else begin
            p1_vld_ff <= issue_on_ff;
            p2_vld_ff <= p1_vld_ff;
            p3_vld_ff <= p2_vld_ff;
         end
         if (flush || (issue_on_ff && (issue_idx_ff == issue_end_ff))) begin
            issue_on_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && cmd.is_query && (count_ff != '0)) begin
                  issue_on_ff <= 1'b1;
               end
            end
            ST_LASQ: issue_on_ff <= 1'b1;
            ST_WIN: begin
               if (p3_vld_ff && p3_end_ff) begin
                  nearest_ff  <= best_fin;
                  issue_on_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (issue_on_ff) begin
         issue_idx_ff <= IDX_W'(issue_idx_ff + IDX_W'(1));
      end
      p1_idx_ff <= issue_idx_ff;
      p1_end_ff <= (issue_idx_ff == issue_end_ff);
      p2_idx_ff <= p1_idx_ff;
      p2_end_ff <= p1_end_ff;
      p3_idx_ff <= p2_idx_ff;
      p3_end_ff <= p2_end_ff;
      dx_ff     <= ddx[32] ? 32'(-ddx) : ddx[31:0];
      dy_ff     <= ddy[32] ? 32'(-ddy) : ddy[31:0];
      sx_ff     <= dx_ff * dx_ff;
      sy_ff     <= dy_ff * dy_ff;
      case (state_ff)
         ST_IDLE: begin
            rx_ff        <= cmd.pos_x;
            ry_ff        <= cmd.pos_y;
            speed_ff     <= cmd.speed;
            last_ff      <= last_w;
            issue_idx_ff <= last_w;
            issue_end_ff <= last_w;
            status_ff    <= (count_ff == '0);
            loop_ff      <= 1'b0;
            best_ff      <= '0;
            target_ff    <= '0;
         end
         ST_REF: begin
            ref_x_ff <= signed'(ram_q_ff[31:0]);
            ref_y_ff <= signed'(ram_q_ff[63:32]);
         end
         ST_LOOP: begin
            if (p3_vld_ff) begin
               loop_ff  <= (cur_dsq < LOOP_GAP_SQ);
               ref_x_ff <= rx_ff;
               ref_y_ff <= ry_ff;
            end
         end
         ST_MUL: begin
            quo_ff     <= NUM_W'(dmm_mag * clo_mag);
            rem_ff     <= '0;
            den_mag_ff <= den_mag;
            neg_ff     <= dmm_s[23] ^ clo_s[16] ^ den_s[16];
            div_cnt_ff <= '0;
         end
         ST_DIV: begin
            rem_ff     <= div_bit ? 16'(div_t - {1'b0, den_mag_ff}) : div_t;
            quo_ff     <= {quo_ff[NUM_W-2:0], div_bit};
            div_cnt_ff <= DIV_CNT_W'(div_cnt_ff + DIV_CNT_W'(1));
         end
         ST_LAFIN: begin
            lu_ff <= la_u;
            uu_ff <= 24'(la_u + BAND);
         end
         ST_LASQ: begin
            lsq_ff       <= lu_ff * lu_ff;
            usq_ff       <= uu_ff * uu_ff;
            issue_idx_ff <= win_start;
            issue_end_ff <= win_end;
            first_ff     <= 1'b1;
         end
         ST_WIN: begin
            if (p3_vld_ff) begin
               first_ff <= 1'b0;
               if (better) begin
                  best_ff  <= p3_idx_ff;
                  bestd_ff <= cur_dsq;
               end
               if (p3_end_ff) begin
                  issue_idx_ff <= best_fin;
                  issue_end_ff <= last_ff;
                  target_ff    <= loop_ff ? '0 : last_ff;
               end
            end
         end
         ST_TGT: begin
            if (p3_vld_ff && hit) begin
               target_ff <= p3_idx_ff;
            end
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_target_ff  <= 10'(target_ff);
         rsp_closest_ff <= 10'(best_ff);
         rsp_in_loop_ff <= loop_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_target_index  = rsp_target_ff;
   assign rsp_closest_index = rsp_closest_ff;
   assign rsp_in_loop       = rsp_in_loop_ff;

endmodule

// ----- dv/testbench.sv -----
module testbench;
   import lwsel_pkg::*;

   typedef struct {
      logic               kind;
      logic               new_path;
      logic signed [31:0] wp_x;
      logic signed [31:0] wp_y;
      logic signed [31:0] robot_x;
      logic signed [31:0] robot_y;
      logic signed [15:0] speed;
   } wp_txn_type;

   typedef struct {
      logic       status;
      logic [9:0] target_index;
      logic [9:0] closest_index;
      logic       in_loop;
   } target_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_kind = 1'b0;
   logic               req_new_path = 1'b0;
   logic signed [31:0] req_wp_x = '0;
   logic signed [31:0] req_wp_y = '0;
   logic signed [31:0] req_robot_x = '0;
   logic signed [31:0] req_robot_y = '0;
   logic signed [15:0] req_speed = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_status;
   logic [9:0]         rsp_target_index;
   logic [9:0]         rsp_closest_index;
   logic               rsp_in_loop;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [22:0]        csr_wdata = '0;

   lookahead_waypoint_selector dut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic signed [31:0] path_x [MAX_WAYPOINTS];
   logic signed [31:0] path_y [MAX_WAYPOINTS];
   int unsigned        path_len = 0;
   int unsigned        near_idx = 0;
   longint             la_min, la_max, spd_lo, spd_hi;

   wp_txn_type pending_txns [$];
   target_type expected_targets [$];
   int      errors = 0;
   int      send_idle_pct, recv_stall_pct;
   bit      hold_go = 1'b0;
   bit      long_hold = 1'b0;
   int      hold_cycles = 0;

   function automatic logic [64:0] dist_sq(logic signed [31:0] ax, logic signed [31:0] ay,
                                           logic signed [31:0] bx, logic signed [31:0] by);
      longint     dx, dy;
      logic [64:0] ux, uy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ux = 65'(dx);
      uy = 65'(dy);
      return ux * ux + uy * uy;
   endfunction

   function automatic longint lookahead_dist(logic signed [15:0] v);
      longint c, q, sv;
      sv = longint'(v);
      c = (sv < spd_lo) ? spd_lo : ((sv > spd_hi) ? spd_hi : sv);
      if (spd_hi == spd_lo) return la_min;
      // signed division truncates toward zero
      q = ((la_max - la_min) * (c - spd_lo)) / (spd_hi - spd_lo) + la_min;
      return (q < 0) ? 0 : q;
   endfunction

   function automatic void predict_target(wp_txn_type t);
      int unsigned last, n, first, stop, best, tgt;
      logic [64:0] d, best_d, lo_sq, hi_sq, la_w, hi_w;
      logic        looped;
      target_type  r;
      if (!t.kind) begin
         if (t.new_path) path_len = 0;
         if (path_len < MAX_WAYPOINTS) begin
            path_x[path_len] = t.wp_x;
            path_y[path_len] = t.wp_y;
            path_len++;
         end
         return;
      end
      if (path_len == 0) begin
         r = '{1'b1, 10'd0, 10'd0, 1'b0};
         expected_targets.insert(expected_targets.size(), r);
         return;
      end
      last = path_len - 1;
      looped = dist_sq(path_x[0], path_y[0], path_x[last], path_y[last]) < LOOP_GAP_SQ;
      n = (near_idx > last) ? last : near_idx;
      first = (n >= WINDOW_BACK) ? n - WINDOW_BACK : 0;
      stop = (last - n > WINDOW_FORWARD) ? n + WINDOW_FORWARD : last;
      best = first;
      best_d = dist_sq(path_x[first], path_y[first], t.robot_x, t.robot_y);
      for (int unsigned i = first + 1; i <= stop; i++) begin
         d = dist_sq(path_x[i], path_y[i], t.robot_x, t.robot_y);
         if (d < best_d) begin
            best_d = d;
            best = i;
         end
      end
      near_idx = best;
      la_w = 65'(lookahead_dist(t.speed));
      hi_w = la_w + 65'(BAND);
      lo_sq = la_w * la_w;
      hi_sq = hi_w * hi_w;
      tgt = looped ? 0 : last;
      for (int unsigned i = best; i <= last; i++) begin
         d = dist_sq(path_x[i], path_y[i], t.robot_x, t.robot_y);
         if (lo_sq < d && d < hi_sq) begin
            tgt = i;
            break;
         end
      end
      r = '{1'b0, tgt[9:0], best[9:0], looped};
      expected_targets.insert(expected_targets.size(), r);
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_target(pending_txns[0]);
            void'(pending_txns.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (pending_txns.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid    <= 1'b1;
               req_kind     <= pending_txns[0].kind;
               req_new_path <= pending_txns[0].new_path;
               req_wp_x     <= pending_txns[0].wp_x;
               req_wp_y     <= pending_txns[0].wp_y;
               req_robot_x  <= pending_txns[0].robot_x;
               req_robot_y  <= pending_txns[0].robot_y;
               req_speed    <= pending_txns[0].speed;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, started once by hold_go
   always @(posedge clock) begin
      if (hold_go && hold_cycles < 3000) begin
         long_hold   <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         long_hold <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_targets.size() == 0) begin
               $display("%0t: unexpected transaction status=%0d target=%0d closest=%0d loop=%0d",
                        $time, rsp_status, rsp_target_index, rsp_closest_index, rsp_in_loop);
               errors++;
            end else begin
               target_type e;
               e = expected_targets.pop_front();
               if (e.status !== rsp_status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
                  errors++;
               end
               if (e.target_index !== rsp_target_index) begin
                  $display("%0t: target_index expected %0d actual %0d",
                           $time, e.target_index, rsp_target_index);
                  errors++;
               end
               if (e.closest_index !== rsp_closest_index) begin
                  $display("%0t: closest_index expected %0d actual %0d",
                           $time, e.closest_index, rsp_closest_index);
                  errors++;
               end
               if (e.in_loop !== rsp_in_loop) begin
                  $display("%0t: in_loop expected %0d actual %0d", $time, e.in_loop, rsp_in_loop);
                  errors++;
               end
            end
         end
         rsp_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic add_load(bit np, logic signed [31:0] x, logic signed [31:0] y);
      wp_txn_type t;
      t = '{1'b0, np, x, y, $urandom, $urandom, 16'($urandom)};
      pending_txns.insert(pending_txns.size(), t);
   endtask

   task automatic add_query(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [15:0] v);
      wp_txn_type t;
      t = '{1'b1, 1'($urandom), $urandom, $urandom, x, y, v};
      pending_txns.insert(pending_txns.size(), t);
   endtask

   task automatic wait_idle();
      while (pending_txns.size() > 0 || req_valid || expected_targets.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [22:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LA_MIN:     la_min = longint'(val);
         CSR_LA_MAX:     la_max = longint'(val);
         CSR_SPEED_LOW:  spd_lo = longint'(val[14:0]);
         CSR_SPEED_HIGH: spd_hi = longint'(val[14:0]);
         default: ;
      endcase
   endtask

   task automatic set_regs(int mn, int mx, int lo, int hi);
      write_csr(CSR_LA_MIN, 23'(mn));
      write_csr(CSR_LA_MAX, 23'(mx));
      write_csr(CSR_SPEED_LOW, 23'(lo));
      write_csr(CSR_SPEED_HIGH, 23'(hi));
   endtask

   function automatic logic signed [15:0] pick_speed();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'(spd_lo) + 16'($urandom_range(8)) - 16'sd4;
         2: return 16'(spd_hi) + 16'($urandom_range(8)) - 16'sd4;
         default: return 16'($urandom_range(32767));
      endcase
   endfunction

   // a path along a line, or a rectangle that closes on itself
   task automatic add_path(int len, bit closed);
      int x0, y0, stp, px, py, side;
      x0 = $urandom_range(2000000) - 1000000;
      y0 = $urandom_range(2000000) - 1000000;
      stp = 32768 + $urandom_range(131072);
      side = (len + 3) / 4;
      for (int i = 0; i < len; i++) begin
         if (!closed) begin
            px = x0 + i * stp;
            py = y0 + $urandom_range(65536) - 32768;
         end else if (i < side) begin
            px = x0 + i * stp;  py = y0;
         end else if (i < 2 * side) begin
            px = x0 + side * stp;  py = y0 + (i - side) * stp;
         end else if (i < 3 * side) begin
            px = x0 + (3 * side - i) * stp;  py = y0 + side * stp;
         end else begin
            px = x0;  py = y0 + (4 * side - i) * stp;
         end
         add_load(i == 0, px, py);
      end
   endtask

   task automatic add_walk(int nq);
      int k;
      k = 0;
      for (int q = 0; q < nq; q++) begin
         k = k + $urandom_range(4);
         if (k >= path_len) k = 0;
         if ($urandom_range(9) == 0)
            add_query($urandom, $urandom, pick_speed());
         else
            add_query(path_x[k] + $urandom_range(131072) - 65536,
                      path_y[k] + $urandom_range(131072) - 65536, pick_speed());
      end
   endtask

   initial begin
      int items, len;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      la_min = 0; la_max = 0; spd_lo = 0; spd_hi = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty path, all-zero registers, field extremes
      add_query(32'sh7fffffff, 32'sh80000000, 16'sh7fff);
      add_load(1'b1, 32'sh80000000, 32'sh80000000);
      add_load(1'b0, 32'sh7fffffff, 32'sh7fffffff);
      add_query(32'sh7fffffff, 32'sh80000000, 16'sh8000);
      add_query(32'shffffffff, 32'sh00000000, 16'shffff);
      wait_idle();
      set_regs(131072, 655360, 0, 1280);
      // closed loop, then an open path walked forward
      add_path(20, 1'b1);
      wait_idle();
      add_walk(3);
      add_path(30, 1'b0);
      wait_idle();
      for (int i = 0; i < 30; i += 10) add_query(path_x[i], path_y[i], 16'sd640);
      add_query(path_x[29], path_y[29], 16'sd2000);
      // short path leaves the remembered nearest index beyond its end
      add_path(4, 1'b0);
      add_query(32'sd0, 32'sd0, -16'sd5);
      wait_idle();
      set_regs(6553600, 6553600, 32767, 32767);
      add_walk(2);
      wait_idle();
      set_regs(6553600, 0, 32767, 0);
      add_walk(2);
      wait_idle();
      set_regs(0, 6553600, 100, 100);
      add_walk(2);
      wait_idle();

      items = 0;
      for (int b = 0; items < 560; b++) begin
         case (b % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         if ($urandom_range(3) == 0)
            set_regs($urandom_range(6553600), $urandom_range(6553600),
                     $urandom_range(32767), $urandom_range(32767));
         else
            set_regs($urandom_range(400000), 200000 + $urandom_range(1500000),
                     $urandom_range(300), 400 + $urandom_range(2000));
         len = 2 + $urandom_range(35);
         add_path(len, $urandom_range(2) == 0);
         wait_idle();
         if (b == 5) hold_go = 1'b1;
         add_walk(8 + $urandom_range(8));
         if ($urandom_range(3) == 0) add_load(1'b0, $urandom, $urandom);
         items += len + 16;
         wait_idle();
      end
      repeat (100) @(posedge clock);

      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #(12 * 4000000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
